### hdl/fra_pkg.sv
// Shared types and constants for the fenced ring allocator.
// Depends on nothing; every other file but fra_ram imports it.
`default_nettype none

package fra_pkg;

   localparam int BASE_W      = 20;
   localparam int CAP_W       = 21;
   localparam int CNT_W       = 21;
   localparam int POS_W       = 21;
   localparam int FENCE_W     = 64;
   localparam int HC_W        = 32;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 21;
   localparam int BIT_IDX_W   = 5;

   localparam int MARKER_DEPTH_DEF = 8;

   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(1048576);
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ACQUIRE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RECLAIM   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END_FRAME = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_WAIT      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_QUEUE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NO_MARKER = 3'd4;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_BASE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_CAPACITY = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLACE,
      ST_REDUCE,
      ST_OVERRUN,
      ST_RECLAIM,
      ST_LOOKUP,
      ST_CHECK,
      ST_PUSH,
      ST_DONE
   } fra_state_type;

   typedef struct packed {
      logic                load;
      logic                rem_init;
      logic                rem_step;
      logic                place;
      logic                pop;
      logic                push;
      logic                set_wait;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
   } fra_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              too_large;
      logic              pos_ge_cap;
      logic              rem_last;
      logic              over;
      logic              q_empty;
      logic              q_full;
      logic              fence_ok;
   } fra_stat_type;

endpackage

`default_nettype wire

### hdl/fra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### hdl/fra_ctrl.sv
// Sequencer for the fenced ring allocator: one request at a time.
// Depends on fra_pkg; drives fra_dp through fra_cmd_type.
`default_nettype none

module fra_ctrl
   import fra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire fra_stat_type      stat,
   output fra_cmd_type            cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   fra_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_kind)
                  KIND_ACQUIRE:   state_in = ST_PLACE;
                  KIND_RECLAIM:   state_in = ST_RECLAIM;
                  KIND_END_FRAME: state_in = ST_PUSH;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_PLACE: begin
            if (stat.too_large) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_TOO_LARGE;
               state_in        = ST_DONE;
            end else if (stat.pos_ge_cap) begin
               cmd.rem_init = 1'b1;
               state_in     = ST_REDUCE;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_OVERRUN;
            end
         end
         ST_REDUCE: begin
            cmd.rem_step = 1'b1;
            if (stat.rem_last) begin
               state_in = ST_PLACE;
            end
         end
         ST_OVERRUN: begin
            if (!stat.over) begin
               state_in = ST_DONE;
            end else if (stat.q_empty) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_NO_MARKER;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_RECLAIM: begin
            if (stat.q_empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.fence_ok) begin
               cmd.pop  = 1'b1;
               state_in = (stat.kind == KIND_ACQUIRE) ? ST_OVERRUN : ST_RECLAIM;
            end else begin
               cmd.set_wait = (stat.kind == KIND_ACQUIRE);
               state_in     = ST_DONE;
            end
         end
         ST_PUSH: begin
            if (stat.q_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_QUEUE_FULL;
            end else begin
               cmd.push = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("response strobe not followed by idle");

   a_pop_only_in_check: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> state_ff == ST_CHECK && stat.fence_ok)
      else $error("marker retired outside a fence check");

endmodule

`default_nettype wire

### hdl/fra_dp.sv
// Datapath: config registers, ring counters, modulo unit, marker queue.
// Depends on fra_pkg and fra_ram; commanded by fra_ctrl.
`default_nettype none

module fra_dp
   import fra_pkg::*;
#(
   parameter int MARKER_DEPTH = MARKER_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [CNT_W-1:0]      req_count,
   input  wire logic [FENCE_W-1:0]    req_completed_fence,
   input  wire fra_cmd_type           cmd,
   output fra_stat_type               stat,
   output logic [POS_W-1:0]           rsp_slot_offset,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [FENCE_W-1:0]         rsp_wait_fence,
   output logic [FENCE_W-1:0]         rsp_signal_fence
);

   localparam int PTR_W   = $clog2(MARKER_DEPTH);
   localparam int MCNT_W  = $clog2(MARKER_DEPTH + 1);
   localparam int ENTRY_W = HC_W + FENCE_W;
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(MARKER_DEPTH - 1);
   localparam logic [MCNT_W-1:0] MCNT_FULL = MCNT_W'(MARKER_DEPTH);

   // configuration; capacity is stored already clamped to 1..CAP_MAX
   logic [BASE_W-1:0] ring_base_ff;
   logic [CAP_W-1:0]  ring_cap_ff;

   // latched request
   logic [KIND_W-1:0]  kind_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [FENCE_W-1:0] done_ff;

   // ring state
   logic [HC_W-1:0]    head_count_ff, tail_count_ff;
   logic [POS_W-1:0]   head_pos_ff;
   logic [FENCE_W-1:0] fence_ff;
   logic [PTR_W-1:0]   rd_ptr_ff, wr_ptr_ff;
   logic [MCNT_W-1:0]  mcount_ff;

   // modulo unit
   logic [POS_W-1:0]     rem_ff;
   logic [BIT_IDX_W-1:0] bit_idx_ff;

   // results
   logic [POS_W-1:0]    offset_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [FENCE_W-1:0]  wait_ff, signal_ff;

   logic [ENTRY_W-1:0] rd_entry, wr_entry;
   logic [HC_W-1:0]    rd_head;
   logic [FENCE_W-1:0] rd_fence, fence_in;

   logic [CAP_W-1:0] cap_in;
   logic [POS_W:0]   rem_shift, rem_sub;
   logic [POS_W-1:0] rem_in;
   logic [POS_W:0]   sum, npos, adv;
   logic             wrap;
   logic [POS_W-1:0] run_start, head_pos_in;
   logic [HC_W-1:0]  outstanding;

   fra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MARKER_DEPTH)
   ) u_marker_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_entry)
   );

   assign rd_head  = rd_entry[ENTRY_W-1:FENCE_W];
   assign rd_fence = rd_entry[FENCE_W-1:0];
   assign fence_in = fence_ff + FENCE_W'(1);
   assign wr_entry = {head_count_ff, fence_in};

   always_comb begin
      if (csr_data == '0) begin
         cap_in = CAP_W'(1);
      end else if (csr_data > CAP_MAX) begin
         cap_in = CAP_MAX;
      end else begin
         cap_in = csr_data;
      end
   end

   // one restoring remainder step per cycle, MSB first
   assign rem_shift = {rem_ff, head_pos_ff[bit_idx_ff]};
   assign rem_sub   = rem_shift - {1'b0, ring_cap_ff};
   assign rem_in    = (rem_shift >= {1'b0, ring_cap_ff}) ? rem_sub[POS_W-1:0]
                                                         : rem_shift[POS_W-1:0];

   // run placement; head_pos_ff is below capacity here
   assign sum       = {1'b0, head_pos_ff} + {1'b0, count_ff};
   assign wrap      = sum > {1'b0, ring_cap_ff};
   assign run_start = wrap ? '0 : head_pos_ff;
   assign npos      = wrap ? {1'b0, count_ff} : sum;
   assign adv       = wrap ? ({1'b0, ring_cap_ff} - {1'b0, head_pos_ff} + {1'b0, count_ff})
                           : {1'b0, count_ff};
   assign head_pos_in = (npos >= {1'b0, ring_cap_ff}) ? '0 : npos[POS_W-1:0];

   assign outstanding = head_count_ff - tail_count_ff;

   always_comb begin
      stat            = '0;
      stat.kind       = kind_ff;
      stat.too_large  = count_ff > ring_cap_ff;
      stat.pos_ge_cap = head_pos_ff >= ring_cap_ff;
      stat.rem_last   = (bit_idx_ff == '0);
      stat.over       = outstanding > HC_W'(ring_cap_ff);
      stat.q_empty    = (mcount_ff == '0);
      stat.q_full     = (mcount_ff >= MCNT_FULL);
      stat.fence_ok   = rd_fence <= done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_base_ff  <= '0;
         ring_cap_ff   <= CAP_RESET;
         head_count_ff <= '0;
         tail_count_ff <= '0;
         head_pos_ff   <= '0;
         fence_ff      <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         mcount_ff     <= '0;
      end else begin
         if (csr_we && csr_index == CSR_RING_BASE) begin
            ring_base_ff <= csr_data[BASE_W-1:0];
         end
         if (csr_we && csr_index == CSR_RING_CAPACITY) begin
            ring_cap_ff <= cap_in;
         end
         if (cmd.rem_step && stat.rem_last) begin
            head_pos_ff <= rem_in;
         end
         if (cmd.place) begin
            head_count_ff <= head_count_ff + HC_W'(adv);
            head_pos_ff   <= head_pos_in;
         end
         if (cmd.pop) begin
            tail_count_ff <= rd_head;
            rd_ptr_ff     <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
            mcount_ff     <= mcount_ff - MCNT_W'(1);
         end
         if (cmd.push) begin
            fence_ff  <= fence_in;
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
            mcount_ff <= mcount_ff + MCNT_W'(1);
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         count_ff  <= req_count;
         done_ff   <= req_completed_fence;
         offset_ff <= '0;
         status_ff <= STAT_OK;
         wait_ff   <= '0;
         signal_ff <= '0;
      end
      if (cmd.rem_init) begin
         rem_ff     <= '0;
         bit_idx_ff <= BIT_IDX_W'(POS_W - 1);
      end
      if (cmd.rem_step) begin
         rem_ff     <= rem_in;
         bit_idx_ff <= bit_idx_ff - BIT_IDX_W'(1);
      end
      if (cmd.place) begin
         offset_ff <= POS_W'({1'b0, ring_base_ff}) + run_start;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.set_wait) begin
         status_ff <= STAT_WAIT;
         wait_ff   <= rd_fence;
      end
      if (cmd.push) begin
         signal_ff <= fence_in;
      end
   end

   assign rsp_slot_offset  = offset_ff;
   assign rsp_status       = status_ff;
   assign rsp_wait_fence   = wait_ff;
   assign rsp_signal_fence = signal_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      mcount_ff <= MCNT_FULL)
      else $error("marker count above queue depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.q_empty)
      else $error("retire from empty marker queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.q_full)
      else $error("push into full marker queue");

   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> head_pos_ff < ring_cap_ff)
      else $error("head position left the ring after placement");

endmodule

`default_nettype wire

### hdl/fenced_ring_allocator.sv
// Top level of the fenced ring allocator: controller plus datapath.
// Depends on fra_pkg, fra_ctrl, fra_dp (which holds fra_ram).
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------------
//  request   req_kind, req_count, req_completed_fence start & !busy accepts
//  response  rsp_slot_offset, rsp_status,             rsp_strobe, one cycle, no stall
//            rsp_wait_fence, rsp_signal_fence
//  csr       csr_index, csr_data                      csr_valid & csr_ready (always 1)
//
// One transaction at a time: busy from acceptance to the response strobe.
// A plain acquire places the run and checks for overrun; a too-large acquire, end of frame,
// empty reclaim and unknown kind end without that. Reclaim looks up and checks markers in turn,
// retiring each whose fence is done, until the queue is empty or a pending fence ends the scan.
// On overrun an acquire retires markers the same way until it ends, a fence is pending or none is left
// (the marker RAM read is registered, so each fence check is preceded by a lookup state).
// An acquire whose head position is not below the current capacity first runs a bit-serial
// remainder; this only follows a capacity change.
// Reset is synchronous; the marker RAM is not cleared, the queue starts empty.
// The response cannot be stalled: it is valid only in the strobe cycle.
`default_nettype none

module fenced_ring_allocator
   import fra_pkg::*;
#(
   parameter int MARKER_DEPTH = MARKER_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   // request
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [CNT_W-1:0]      req_count,
   input  wire logic [FENCE_W-1:0]    req_completed_fence,

   // response
   output logic                       rsp_strobe,
   output logic [POS_W-1:0]           rsp_slot_offset,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [FENCE_W-1:0]         rsp_wait_fence,
   output logic [FENCE_W-1:0]         rsp_signal_fence,

   // configuration
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   fra_cmd_type  cmd;
   fra_stat_type stat;

   // config writes are taken as they come, so the port never pushes back
   assign csr_ready = 1'b1;

   fra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_kind),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   fra_dp #(
      .MARKER_DEPTH (MARKER_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_valid & csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_kind            (req_kind),
      .req_count           (req_count),
      .req_completed_fence (req_completed_fence),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_slot_offset     (rsp_slot_offset),
      .rsp_status          (rsp_status),
      .rsp_wait_fence      (rsp_wait_fence),
      .rsp_signal_fence    (rsp_signal_fence)
   );

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for fenced_ring_allocator: directed and random transactions with a scoreboard.
// Depends on fra_pkg and the allocator RTL; needs no other file.

import fra_pkg::*;

// One response transaction, as the scoreboard expects it
typedef struct {
   bit [POS_W-1:0]    slot_offset;
   bit [STATUS_W-1:0] status;
   bit [FENCE_W-1:0]  wait_fence;
   bit [FENCE_W-1:0]  signal_fence;
} alloc_rsp_type;

class alloc_scoreboard;
   // shadow of the CSRs
   bit [BASE_W-1:0]  ring_base;
   bit [CAP_W-1:0]   ring_cap;
   // shadow of the ring and marker queue
   bit [HC_W-1:0]    head_count;
   bit [HC_W-1:0]    tail_count;
   bit [POS_W-1:0]   head_pos;
   bit [FENCE_W-1:0] fence_ctr;
   bit [HC_W-1:0]    mark_head[MARKER_DEPTH_DEF];
   bit [FENCE_W-1:0] mark_fence[MARKER_DEPTH_DEF];
   int               rd_ptr;
   int               wr_ptr;
   int               mark_cnt;
   alloc_rsp_type    awaited[$];
   int               failures;

   function new();
      ring_base  = '0;
      ring_cap   = CAP_RESET;
      head_count = '0;
      tail_count = '0;
      head_pos   = '0;
      fence_ctr  = '0;
      rd_ptr     = 0;
      wr_ptr     = 0;
      mark_cnt   = 0;
      failures   = 0;
   endfunction

   // capacity as the block uses it: 0 acts as 1, clipped at CAP_MAX
   function bit [HC_W-1:0] usable_cap();
      if (ring_cap == 0) return 1;
      if (ring_cap > CAP_MAX) return HC_W'(CAP_MAX);
      return HC_W'(ring_cap);
   endfunction

   function void note_csr(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] data);
      if (idx == CSR_RING_BASE) ring_base = data[BASE_W-1:0];
      else if (idx == CSR_RING_CAPACITY) ring_cap = data;
   endfunction

   function void retire_oldest();
      tail_count = mark_head[rd_ptr];
      rd_ptr = (rd_ptr + 1) % MARKER_DEPTH_DEF;
      mark_cnt--;
   endfunction

   // advance the shadow state by one request and queue the response it must give
   function void note_request(bit [KIND_W-1:0] kind, bit [CNT_W-1:0] count,
                              bit [FENCE_W-1:0] fence_done);
      alloc_rsp_type rsp;
      bit [HC_W-1:0] cap;
      bit [HC_W-1:0] pos;
      bit [HC_W-1:0] npos;
      rsp = '{default: 0};
      case (kind)
         KIND_ACQUIRE: begin
            cap = usable_cap();
            if (HC_W'(count) > cap) begin
               rsp.status = STAT_TOO_LARGE;
            end else begin
               pos = HC_W'(head_pos) % cap;
               // run would cross the end: skip to slot 0, remainder is wasted
               if (pos + count > cap) begin
                  head_count += cap - pos;
                  pos = 0;
               end
               head_count += count;
               npos = pos + count;
               head_pos = (npos >= cap) ? '0 : POS_W'(npos);
               while (head_count - tail_count > cap) begin
                  if (mark_cnt == 0) begin
                     rsp.status = STAT_NO_MARKER;
                     break;
                  end
                  if (mark_fence[rd_ptr] <= fence_done) begin
                     retire_oldest();
                  end else begin
                     rsp.status = STAT_WAIT;
                     rsp.wait_fence = mark_fence[rd_ptr];
                     break;
                  end
               end
               rsp.slot_offset = POS_W'(ring_base + pos);
            end
         end
         KIND_RECLAIM: begin
            while (mark_cnt != 0 && mark_fence[rd_ptr] <= fence_done) retire_oldest();
         end
         KIND_END_FRAME: begin
            if (mark_cnt >= MARKER_DEPTH_DEF) begin
               rsp.status = STAT_QUEUE_FULL;
            end else begin
               fence_ctr++;
               mark_head[wr_ptr] = head_count;
               mark_fence[wr_ptr] = fence_ctr;
               wr_ptr = (wr_ptr + 1) % MARKER_DEPTH_DEF;
               mark_cnt++;
               rsp.signal_fence = fence_ctr;
            end
         end
         default: ;
      endcase
      awaited.push_back(rsp);
   endfunction

   function void compare_field(string name, bit [FENCE_W-1:0] exp_val,
                               logic [FENCE_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         failures++;
      end
   endfunction

   function void check_response(logic [POS_W-1:0] slot_offset, logic [STATUS_W-1:0] status,
                                logic [FENCE_W-1:0] wait_fence,
                                logic [FENCE_W-1:0] signal_fence);
      alloc_rsp_type exp_rsp;
      if (awaited.size() == 0) begin
         $error("response strobe with no transaction outstanding");
         failures++;
         return;
      end
      exp_rsp = awaited[0];
      awaited.delete(0);
      compare_field("slot_offset", FENCE_W'(exp_rsp.slot_offset), FENCE_W'(slot_offset));
      compare_field("status", FENCE_W'(exp_rsp.status), FENCE_W'(status));
      compare_field("wait_fence", exp_rsp.wait_fence, wait_fence);
      compare_field("signal_fence", exp_rsp.signal_fence, signal_fence);
   endfunction
endclass

module tb_top;

   localparam int HALF_PERIOD = 5;

   // codes the package leaves unnamed: reserved request kind, unmapped CSR slot
   localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd2;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [CNT_W-1:0]      req_count = '0;
   logic [FENCE_W-1:0]    req_completed_fence = '0;
   logic                  rsp_strobe;
   logic [POS_W-1:0]      rsp_slot_offset;
   logic [STATUS_W-1:0]   rsp_status;
   logic [FENCE_W-1:0]    rsp_wait_fence;
   logic [FENCE_W-1:0]    rsp_signal_fence;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   alloc_scoreboard sb;

   fenced_ring_allocator #(
      .MARKER_DEPTH (MARKER_DEPTH_DEF)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_count           (req_count),
      .req_completed_fence (req_completed_fence),
      .rsp_strobe          (rsp_strobe),
      .rsp_slot_offset     (rsp_slot_offset),
      .rsp_status          (rsp_status),
      .rsp_wait_fence      (rsp_wait_fence),
      .rsp_signal_fence    (rsp_signal_fence),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Monitor. Everything the DUT drives changes on NBAs at the edge, so values read
   // here are the ones that held during the cycle the edge closes. A response is
   // checked before a request accepted on the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_response(rsp_slot_offset, rsp_status, rsp_wait_fence, rsp_signal_fence);
         if (start && !busy)
            sb.note_request(req_kind, req_count, req_completed_fence);
         if (csr_valid && csr_ready)
            sb.note_csr(csr_index, csr_data);
      end
   end

   // Present one request and hold it until the DUT takes it. start stays high on
   // return so back-to-back transactions need no extra assignment.
   task automatic issue(input logic [KIND_W-1:0] kind, input logic [CNT_W-1:0] count,
                        input logic [FENCE_W-1:0] fence_done);
      start <= 1'b1;
      req_kind <= kind;
      req_count <= count;
      req_completed_fence <= fence_done;
      do @(posedge clock); while (busy);
   endtask

   // Idle the request side; junk on the payload must be ignored while start is low.
   task automatic pause(input int cycles);
      start <= 1'b0;
      req_kind <= KIND_W'($urandom);
      req_count <= CNT_W'($urandom);
      req_completed_fence <= {$urandom, $urandom};
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait for the DUT to go quiet with nothing outstanding.
   // Bounded so a lost response shows up as a leftover rather than a hang.
   task automatic settle(input int tail_cycles);
      int waited;
      waited = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while ((sb.awaited.size() != 0 || busy) && waited < 4000);
      repeat (tail_cycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Reprogram the ring only with the allocator idle.
   task automatic set_ring(input logic [CSR_DATA_W-1:0] base, input logic [CSR_DATA_W-1:0] cap);
      settle(4);
      csr_write(CSR_RING_BASE, base);
      csr_write(CSR_RING_CAPACITY, cap);
      csr_valid <= 1'b0;
   endtask

   // Random traffic in bursts. Mostly acquire/end-of-frame so the ring overruns and
   // markers pile up; fences track the live counter so both wait and retire paths hit.
   // Reserved-kind requests do not count toward the item total.
   task automatic run_traffic(input int items);
      int sent;
      int burst;
      int sel;
      bit [HC_W-1:0]    cap;
      bit [KIND_W-1:0]  kind;
      bit [CNT_W-1:0]   count;
      bit [FENCE_W-1:0] fence_done;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            cap = sb.usable_cap();
            sel = $urandom_range(0, 99);
            if (sel < 55) kind = KIND_ACQUIRE;
            else if (sel < 80) kind = KIND_END_FRAME;
            else if (sel < 95) kind = KIND_RECLAIM;
            else kind = KIND_UNUSED;
            sel = $urandom_range(0, 99);
            if (sel < 65) count = CNT_W'($urandom_range(0, cap / 3));
            else if (sel < 80) count = CNT_W'($urandom_range(cap > 4 ? cap - 4 : 0, cap));
            else if (sel < 85) count = '0;
            else if (sel < 93) count = CNT_W'(cap + $urandom_range(1, 8));
            else count = CNT_W'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 50) fence_done = sb.fence_ctr - FENCE_W'($urandom_range(0, 3));
            else if (sel < 65) fence_done = '0;
            else if (sel < 80) fence_done = '1;
            else fence_done = {$urandom, $urandom};
            issue(kind, count, fence_done);
            if (kind != KIND_UNUSED) sent++;
         end
         // a quarter of bursts run straight into the next one
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset CSR values (base 0, capacity 1024) ---
      issue(KIND_ACQUIRE, '0, '0);
      issue(KIND_ACQUIRE, CNT_W'(1025), '0);          // just over capacity
      issue(KIND_ACQUIRE, '1, '1);                    // max count, too large
      issue(KIND_RECLAIM, '0, '1);                    // nothing queued
      issue(KIND_UNUSED, CNT_W'($urandom), {$urandom, $urandom});
      issue(KIND_ACQUIRE, CNT_W'(1000), '0);
      issue(KIND_END_FRAME, '0, '0);                  // fence 1 marks head 1000
      issue(KIND_ACQUIRE, CNT_W'(100), '0);           // wraps, overruns, fence 1 pending
      issue(KIND_ACQUIRE, CNT_W'(10), FENCE_W'(1));   // fence 1 done: marker retires
      issue(KIND_ACQUIRE, CNT_W'(1024), '0);          // overrun with the queue empty
      repeat (MARKER_DEPTH_DEF + 1) issue(KIND_END_FRAME, '0, '0);  // last one finds it full
      issue(KIND_RECLAIM, '0, FENCE_W'(4));           // partial reclaim
      issue(KIND_RECLAIM, '0, '1);                    // drain the rest
      issue(KIND_ACQUIRE, CNT_W'(700), '0);           // leave head position at 700

      // shrink capacity under a live head position: start is 700 mod 300
      settle(4);
      csr_write(CSR_UNUSED, '1);                      // unmapped slot, no effect
      csr_write(CSR_RING_BASE, CSR_DATA_W'(21'h112345));  // top bit is dropped
      csr_write(CSR_RING_CAPACITY, CSR_DATA_W'(300));
      csr_valid <= 1'b0;
      issue(KIND_ACQUIRE, CNT_W'(5), '0);

      // zero capacity behaves as a single slot
      set_ring(CSR_DATA_W'(20'hFFFFF), '0);
      issue(KIND_ACQUIRE, CNT_W'(1), '0);
      issue(KIND_ACQUIRE, CNT_W'(2), '0);

      // capacity above the maximum clips to it; full-size run
      set_ring('1, '1);
      issue(KIND_ACQUIRE, CNT_W'(CAP_MAX), '1);

      // --- random phases across ring settings ---
      set_ring(CSR_DATA_W'($urandom), CSR_DATA_W'(64));
      run_traffic(250);
      set_ring('0, CSR_DATA_W'(1));
      run_traffic(100);
      set_ring(CSR_DATA_W'($urandom), '0);
      run_traffic(60);
      set_ring(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(2, 40)));
      run_traffic(300);
      set_ring(CSR_DATA_W'($urandom), '1);
      run_traffic(150);
      set_ring(CSR_DATA_W'($urandom), CSR_DATA_W'(CAP_MAX));
      run_traffic(100);
      set_ring(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(100, 3000)));
      run_traffic(300);
      set_ring(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(0, 2097151)));
      run_traffic(150);
      set_ring('0, CSR_DATA_W'(16));
      run_traffic(240);

      // worst transaction: remainder plus a full reclaim
      settle(60);
      if (sb.awaited.size() != 0) begin
         $error("%0d responses never arrived", sb.awaited.size());
         sb.failures++;
      end
      if (sb.failures == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### sim.f
hdl/fra_pkg.sv
hdl/fra_ram.sv
hdl/fra_ctrl.sv
hdl/fra_dp.sv
hdl/fenced_ring_allocator.sv
dv/tb_top.sv
